/* src/cln_pkg.sv */
// Shared types, codes and the init pin-state table for the LCD nibble writer.
`timescale 1ns / 1ps
package cln_pkg;

   typedef enum logic [1:0] {
      CMD_INIT   = 2'd0,
      CMD_WRITE  = 2'd1,
      CMD_DATA   = 2'd2,
      CMD_CURSOR = 2'd3
   } command_type;

   localparam int unsigned INIT_LEN    = 35;
   localparam int unsigned BYTE_LEN    = 5;
   localparam int unsigned STEP_W      = $clog2(INIT_LEN);
   localparam logic [5:0]  CURSOR_COLS = 6'd40;
   localparam logic [7:0]  CMD_HOLD    = 8'd249;

   // One pin state without the register select level.
   typedef struct packed {
      logic       en;
      logic [3:0] nib;
      logic [7:0] hold;
   } pin_type;

   // Wake-up nibbles, then 0x28, 0x0E, 0x01, 0x06, 0x80 as byte writes.
   localparam pin_type INIT_ROM [INIT_LEN] = '{
      '{1'b0, 4'h3, 8'd39}, '{1'b1, 4'h3, 8'd0}, '{1'b0, 4'h3, 8'd4},
      '{1'b1, 4'h3, 8'd0},  '{1'b0, 4'h3, 8'd4}, '{1'b1, 4'h3, 8'd0},
      '{1'b0, 4'h3, 8'd1},  '{1'b0, 4'h2, 8'd0}, '{1'b1, 4'h2, 8'd0},
      '{1'b0, 4'h2, 8'd0},
      '{1'b0, 4'h2, 8'd0}, '{1'b1, 4'h2, 8'd1}, '{1'b0, 4'h8, 8'd0},
      '{1'b1, 4'h8, 8'd1}, '{1'b0, 4'h8, 8'd249},
      '{1'b0, 4'h0, 8'd0}, '{1'b1, 4'h0, 8'd1}, '{1'b0, 4'hE, 8'd0},
      '{1'b1, 4'hE, 8'd1}, '{1'b0, 4'hE, 8'd249},
      '{1'b0, 4'h0, 8'd0}, '{1'b1, 4'h0, 8'd1}, '{1'b0, 4'h1, 8'd0},
      '{1'b1, 4'h1, 8'd1}, '{1'b0, 4'h1, 8'd249},
      '{1'b0, 4'h0, 8'd0}, '{1'b1, 4'h0, 8'd1}, '{1'b0, 4'h6, 8'd0},
      '{1'b1, 4'h6, 8'd1}, '{1'b0, 4'h6, 8'd249},
      '{1'b0, 4'h8, 8'd0}, '{1'b1, 4'h8, 8'd1}, '{1'b0, 4'h0, 8'd0},
      '{1'b1, 4'h0, 8'd1}, '{1'b0, 4'h0, 8'd249}
   };

   // Five-state byte write: high nibble strobe, then low nibble strobe.
   function automatic pin_type byte_pin(input logic [2:0] k, input logic [7:0] b,
                                        input logic [7:0] final_hold);
      pin_type p;
      case (k)
         3'd0:    p = '{1'b0, b[7:4], 8'd0};
         3'd1:    p = '{1'b1, b[7:4], 8'd1};
         3'd2:    p = '{1'b0, b[3:0], 8'd0};
         3'd3:    p = '{1'b1, b[3:0], 8'd1};
         default: p = '{1'b0, b[3:0], final_hold};
      endcase
      return p;
   endfunction

   typedef struct packed {
      logic load;
      logic issue;
   } ctrl_cmd_type;

   typedef struct packed {
      logic skip;
      logic final_step;
      logic slot_free;
   } dp_stat_type;

endpackage

/* src/cln_if.sv */
// Request and response channel interfaces for the LCD nibble writer.
`timescale 1ns / 1ps
interface cln_req_if;
   logic       valid;
   logic       ready;
   logic [1:0] command;
   logic [7:0] byte_value;
   logic [5:0] column;
   logic       row;
   modport source (output valid, command, byte_value, column, row, input ready);
   modport sink   (input valid, command, byte_value, column, row, output ready);
endinterface

interface cln_rsp_if;
   logic       valid;
   logic       ready;
   logic       reg_select;
   logic       enable_pin;
   logic [3:0] nibble;
   logic [7:0] hold_units;
   logic       last;
   modport source (output valid, reg_select, enable_pin, nibble, hold_units, last,
                   input ready);
   modport sink   (input valid, reg_select, enable_pin, nibble, hold_units, last,
                   output ready);
endinterface

/* src/cln_ctrl.sv */
// Controller: sequences one request at a time through the datapath.
`timescale 1ns / 1ps
module cln_ctrl import cln_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   output logic         req_ready,
   input  dp_stat_type  stat,
   output ctrl_cmd_type cmd
);

   typedef enum logic {IDLE, RUN} state_type;
   state_type state_ff, state_in;

   assign req_ready = (state_ff == IDLE);
   assign cmd.load  = req_valid && req_ready && !stat.skip;
   assign cmd.issue = (state_ff == RUN) && stat.slot_free;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         IDLE: begin
            if (cmd.load) state_in = RUN;
         end
         RUN: begin
            // drop back once the final pin state goes into the output register
            if (cmd.issue && stat.final_step) state_in = IDLE;
         end
         default: state_in = IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

/* src/cln_dp.sv */
// Datapath: request latch, step counter and the output word register.
`timescale 1ns / 1ps
module cln_dp import cln_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  logic [1:0]   command,
   input  logic [7:0]   byte_value,
   input  logic [5:0]   column,
   input  logic         row,
   input  ctrl_cmd_type cmd,
   output dp_stat_type  stat,
   input  logic         rsp_ready,
   output logic         rsp_valid,
   output logic         rsp_reg_select,
   output logic         rsp_enable_pin,
   output logic [3:0]   rsp_nibble,
   output logic [7:0]   rsp_hold_units,
   output logic         rsp_last
);

   logic              init_ff, rs_ff;
   logic [7:0]        byte_ff;
   logic [STEP_W-1:0] step_ff;
   logic              valid_ff, valid_in;
   logic              rs_out_ff, last_out_ff;
   pin_type           pin_out_ff, pin_in;
   logic [7:0]        load_byte;

   assign stat.skip       = (command_type'(command) == CMD_CURSOR) && (column >= CURSOR_COLS);
   assign stat.final_step = init_ff ? (step_ff == STEP_W'(INIT_LEN - 1))
                                    : (step_ff == STEP_W'(BYTE_LEN - 1));
   assign stat.slot_free  = !valid_ff || rsp_ready;

   assign load_byte = (command_type'(command) == CMD_CURSOR) ? {1'b1, row, column}
                                                            : byte_value;

   always_comb begin
      if (init_ff) begin
         pin_in = INIT_ROM[step_ff];
      end else begin
         pin_in = byte_pin(step_ff[2:0], byte_ff, 8'd0);
      end
   end

   always_comb begin
      valid_in = valid_ff;
      if (cmd.issue) begin
         valid_in = 1'b1;
      end else if (rsp_ready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         init_ff <= (command_type'(command) == CMD_INIT);
         rs_ff   <= (command_type'(command) == CMD_DATA);
         byte_ff <= load_byte;
         step_ff <= '0;
      end else if (cmd.issue) begin
         step_ff <= step_ff + STEP_W'(1);
      end
      if (cmd.issue) begin
         pin_out_ff  <= pin_in;
         rs_out_ff   <= rs_ff && !init_ff;
         last_out_ff <= stat.final_step;
      end
   end

   assign rsp_valid      = valid_ff;
   assign rsp_reg_select = rs_out_ff;
   assign rsp_enable_pin = pin_out_ff.en;
   assign rsp_nibble     = pin_out_ff.nib;
   assign rsp_hold_units = pin_out_ff.hold;
   assign rsp_last       = last_out_ff;

endmodule

/* src/char_lcd_nibble_writer.sv */
// Character LCD 4-bit bus writer: top level joining controller and datapath.
// After a request is accepted, the controller enters RUN and the first pin state is
// loaded into the output register once a slot is free. Throughput: one pin state per
// cycle while the response side is ready; an init issues 35 words and a byte write 5,
// and the next request is taken only after the last word; an out-of-range cursor issues none.
// Synchronous active-high reset clears the controller and the output valid flag.
`timescale 1ns / 1ps
module char_lcd_nibble_writer import cln_pkg::*; (
   input logic    clock,
   input logic    reset,
   cln_req_if.sink   req_ch,
   cln_rsp_if.source rsp_ch
);

   ctrl_cmd_type cmd;
   dp_stat_type  stat;

   cln_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_ch.valid),
      .req_ready (req_ch.ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   cln_dp u_dp (
      .clock          (clock),
      .reset          (reset),
      .command        (req_ch.command),
      .byte_value     (req_ch.byte_value),
      .column         (req_ch.column),
      .row            (req_ch.row),
      .cmd            (cmd),
      .stat           (stat),
      .rsp_ready      (rsp_ch.ready),
      .rsp_valid      (rsp_ch.valid),
      .rsp_reg_select (rsp_ch.reg_select),
      .rsp_enable_pin (rsp_ch.enable_pin),
      .rsp_nibble     (rsp_ch.nibble),
      .rsp_hold_units (rsp_ch.hold_units),
      .rsp_last       (rsp_ch.last)
   );

   a_last_enable_low: assert property (@(posedge clock) disable iff (reset)
      rsp_ch.valid && rsp_ch.last |-> !rsp_ch.enable_pin)
      else $error("last word has enable high");

   a_strobe_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_ch.valid && rsp_ch.enable_pin |-> rsp_ch.hold_units <= 8'd1)
      else $error("enable strobe held too long");

   a_no_issue_idle: assert property (@(posedge clock) disable iff (reset)
      req_ch.ready |-> !cmd.issue)
      else $error("word issued while idle");

   a_load_then_issue: assert property (@(posedge clock) disable iff (reset)
      cmd.load && stat.slot_free |-> ##2 rsp_ch.valid)
      else $error("accepted request produced no word");

endmodule
